>>> src/ts_pcr_chunker_unit_defines.svh
// Assertion macros shared by the transport stream chunker modules.
`ifndef TS_PCR_CHUNKER_UNIT_DEFINES_SVH
`define TS_PCR_CHUNKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tpc_pkg.sv
// Shared types and constants of the transport stream chunker.
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int PCR_BITS    = 33;
    localparam int STAMP_BITS  = 37;
    localparam int GATHER_BITS = 32;
    localparam int PPC_BITS    = 16;
    localparam int NPK_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 33;

    localparam logic [7:0] SYNC_BYTE     = 8'h47;
    localparam logic [7:0] ADAPT_BIT     = 8'h20;
    localparam logic [7:0] PCR_BIT       = 8'h10;
    localparam logic [7:0] POS_ADAPT     = 8'd3;
    localparam logic [7:0] POS_FLAGS     = 8'd5;
    localparam logic [7:0] POS_PCR_FIRST = 8'd6;
    localparam logic [7:0] POS_PCR_LAST  = 8'd9;
    localparam logic [7:0] POS_PCR_END   = 8'd10;
    localparam logic [7:0] LAST_POS      = 8'd187;

    localparam logic [4:0] PCR_DIVISOR = 5'd9;
    localparam logic [6:0] STAMP_SCALE = 7'd100;

    // The quotient by nine is the top bits of the product with this rounded-up reciprocal.
    localparam logic [PCR_BITS-1:0] DIV9_MUL   = 33'd7635497416;
    localparam int                  DIV9_SHIFT = 36;

    localparam logic [NPK_BITS-1:0] NPK_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_BITS-1:0] REG_PCR_GAP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PKTS_PER_CHUNK = 2'd1;

    localparam logic [PCR_BITS-1:0] PCR_GAP_RESET = 33'd9000;
    localparam logic [PPC_BITS-1:0] PPC_RESET     = 16'd512;

    typedef struct packed {
        logic                start;
        logic [PCR_BITS-1:0] pcr;
    } pcr_req_t;

    typedef struct packed {
        logic                  keep;
        logic                  chunk_last;
        logic [STAMP_BITS-1:0] timestamp;
        logic [NPK_BITS-1:0]   chunk_packets;
    } res_t;

endpackage

>>> src/tpc_stamp_div.sv
// Pipelined PCR to microsecond converter: divides by nine with a reciprocal multiply, then scales.
`timescale 1ns / 1ps
`include "ts_pcr_chunker_unit_defines.svh"

module tpc_stamp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tpc_pkg::pcr_req_t              req,
    output logic [tpc_pkg::STAMP_BITS-1:0] stamp
);
    import tpc_pkg::*;

    localparam int LO_BITS   = 16;
    localparam int HI_BITS   = PCR_BITS - LO_BITS;
    localparam int PLO_BITS  = LO_BITS + PCR_BITS;
    localparam int PHI_BITS  = HI_BITS + PCR_BITS;
    localparam int PROD_BITS = 2 * PCR_BITS;
    localparam int QUOT_BITS = PROD_BITS - DIV9_SHIFT;

    logic                  s1_reg;
    logic                  s2_reg;
    logic                  s3_reg;
    logic [PCR_BITS-1:0]   x_reg;
    logic [PLO_BITS-1:0]   plo_reg;
    logic [PHI_BITS-1:0]   phi_reg;
    logic [QUOT_BITS-1:0]  q_reg;
    logic [STAMP_BITS-1:0] stamp_reg;

    logic [PLO_BITS-1:0]   plo_next;
    logic [PHI_BITS-1:0]   phi_next;
    logic [PROD_BITS-1:0]  prod_sum;
    logic [QUOT_BITS-1:0]  q_next;
    logic [STAMP_BITS-1:0] stamp_next;

    // The product is split into two partial products so that no multiplier grows too wide.
    assign plo_next   = PLO_BITS'(x_reg[LO_BITS-1:0]) * PLO_BITS'(DIV9_MUL);
    assign phi_next   = PHI_BITS'(x_reg[PCR_BITS-1:LO_BITS]) * PHI_BITS'(DIV9_MUL);
    assign prod_sum   = {phi_reg, {LO_BITS{1'b0}}} + PROD_BITS'(plo_reg);
    assign q_next     = prod_sum[PROD_BITS-1:DIV9_SHIFT];
    assign stamp_next = STAMP_BITS'(q_reg) * STAMP_BITS'(STAMP_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= 1'b0;
            s2_reg    <= 1'b0;
            s3_reg    <= 1'b0;
            x_reg     <= '0;
            plo_reg   <= '0;
            phi_reg   <= '0;
            q_reg     <= '0;
            stamp_reg <= '0;
        end
        else
        begin
            s1_reg <= req.start;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            if (req.start)
            begin
                x_reg <= req.pcr;
            end
            if (s1_reg)
            begin
                plo_reg <= plo_next;
                phi_reg <= phi_next;
            end
            if (s2_reg)
            begin
                q_reg <= q_next;
            end
            if (s3_reg)
            begin
                stamp_reg <= stamp_next;
            end
        end
    end

    assign stamp = stamp_reg;

    `TPC_ASSERT_NOW(a_start_idle, req.start, !(s1_reg || s2_reg || s3_reg), "PCR request while converter busy")
    `TPC_ASSERT_NEXT(a_start_runs, req.start, s1_reg, "Converter did not start")
    `TPC_ASSERT_NEXT(a_stage_flow, s1_reg, s2_reg && !s1_reg, "Converter stage skipped")

endmodule

>>> src/tpc_parser.sv
// Packet sync, PCR extraction and chunk decision for one byte per step.
`timescale 1ns / 1ps
`include "ts_pcr_chunker_unit_defines.svh"

module tpc_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [7:0]                     data_byte,
    input  logic [tpc_pkg::PCR_BITS-1:0]   pcr_gap,
    input  logic [tpc_pkg::PPC_BITS-1:0]   packets_per_chunk,
    input  logic [tpc_pkg::STAMP_BITS-1:0] div_stamp,
    output tpc_pkg::pcr_req_t              req,
    output tpc_pkg::res_t                  res
);
    import tpc_pkg::*;

    localparam int CW = (COUNT_BITS > NPK_BITS) ? COUNT_BITS : NPK_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [7:0]             pos_reg,    pos_next;
    logic                   adapt_reg,  adapt_next;
    logic                   pcrp_reg,   pcrp_next;
    logic [GATHER_BITS-1:0] gather_reg, gather_next;
    logic [PCR_BITS-1:0]    lastpcr_reg, lastpcr_next;
    logic [COUNT_BITS-1:0]  cnt_reg,    cnt_next;
    logic                   cut_reg,    cut_next;

    logic [PCR_BITS-1:0]   pcr;
    logic [PCR_BITS:0]     threshold;
    logic                  pcr_mode;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CW-1:0]         cnt_ext;
    logic                  cut;
    logic                  pcr_start;

    assign pcr       = {gather_reg, data_byte[7]};
    assign threshold = {1'b0, lastpcr_reg} + {1'b0, pcr_gap};
    assign pcr_mode  = (pcr_gap != '0);
    assign cnt_inc   = (cnt_reg != COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt_ext   = CW'(cnt_inc);

    always_comb
    begin
        pos_next     = pos_reg;
        adapt_next   = adapt_reg;
        pcrp_next    = pcrp_reg;
        gather_next  = gather_reg;
        lastpcr_next = lastpcr_reg;
        cnt_next     = cnt_reg;
        cut_next     = cut_reg;
        pcr_start    = 1'b0;
        cut          = 1'b0;
        res          = '0;

        if (pos_reg == '0)
        begin
            if (data_byte == SYNC_BYTE)
            begin
                res.keep    = 1'b1;
                pos_next    = 8'd1;
                adapt_next  = 1'b0;
                pcrp_next   = 1'b0;
                gather_next = '0;
            end
        end
        else
        begin
            res.keep = 1'b1;
            if (pos_reg == POS_ADAPT)
            begin
                adapt_next = ((data_byte & ADAPT_BIT) != '0);
            end
            else if (pos_reg == POS_FLAGS)
            begin
                pcrp_next = adapt_reg && ((data_byte & PCR_BIT) != '0);
            end
            else if (pos_reg inside {[POS_PCR_FIRST:POS_PCR_LAST]})
            begin
                gather_next = {gather_reg[GATHER_BITS-9:0], data_byte};
            end
            else if (pos_reg == POS_PCR_END)
            begin
                if (pcrp_reg && pcr_mode && ({1'b0, pcr} > threshold))
                begin
                    cut_next     = 1'b1;
                    pcr_start    = 1'b1;
                    lastpcr_next = pcr;
                end
            end

            if (pos_reg == LAST_POS)
            begin
                if (pcr_mode)
                begin
                    cut = cut_reg;
                end
                else
                begin
                    cut = (cnt_ext >= CW'(packets_per_chunk));
                end
                if (cut)
                begin
                    res.chunk_last    = 1'b1;
                    res.timestamp     = pcr_mode ? div_stamp : '0;
                    res.chunk_packets = (cnt_ext > CW'(NPK_MAX)) ? NPK_MAX : cnt_ext[NPK_BITS-1:0];
                    cnt_next          = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
                cut_next = 1'b0;
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    assign req.start = step && pcr_start;
    assign req.pcr   = pcr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            adapt_reg   <= 1'b0;
            pcrp_reg    <= 1'b0;
            gather_reg  <= '0;
            lastpcr_reg <= '0;
            cnt_reg     <= '0;
            cut_reg     <= 1'b0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            adapt_reg   <= adapt_next;
            pcrp_reg    <= pcrp_next;
            gather_reg  <= gather_next;
            lastpcr_reg <= lastpcr_next;
            cnt_reg     <= cnt_next;
            cut_reg     <= cut_next;
        end
    end

    `TPC_ASSERT_NOW(a_pos_bound, 1'b1, pos_reg <= LAST_POS, "Packet position out of range")
    `TPC_ASSERT_NOW(a_last_kept, res.chunk_last, res.keep, "Chunk end on a dropped byte")
    `TPC_ASSERT_NEXT(a_cnt_clear, step && res.chunk_last, cnt_reg == '0, "Packet count not cleared")

endmodule

>>> src/ts_pcr_chunker_unit.sv
// Top level of the transport stream chunker: request registers, configuration and core.
//
// Usage: transport stream bytes enter on data_byte with data_valid/data_ready;
// one result per byte leaves on result_valid/result_ready, carrying the byte,
// keep (byte belongs to a synced 188-byte packet), chunk_last and, with
// chunk_last, the chunk timestamp in microseconds (zero when the PCR gap is zero)
// and the packet count. A request is captured in the input register and then in
// the result register, which drives result_valid. One request is taken every
// cycle while the receiver does not stall; the input register and the result
// register form a two-stage pipeline set by the per-byte parser step. PCR to
// microsecond conversion runs in the background in its own registers and is
// ready long before the packet's last byte. When the receiver stalls, the result
// register holds and the input register takes one more request before
// data_ready drops. Reset clears both stages, restores the PCR gap register to
// 9000 and packets_per_chunk to 512, and puts the parser in sync hunting. Configuration
// is written with cfg_we, cfg_index and cfg_data while no request is in flight.
`timescale 1ns / 1ps

module ts_pcr_chunker_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              data_valid,
    output logic                              data_ready,
    input  logic [7:0]                        data_byte,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [7:0]                        out_byte,
    output logic                              keep,
    output logic                              chunk_last,
    output logic [tpc_pkg::STAMP_BITS-1:0]    timestamp,
    output logic [tpc_pkg::NPK_BITS-1:0]      chunk_packets,
    input  logic                              cfg_we,
    input  logic [tpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tpc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import tpc_pkg::*;

    logic                  in_full_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    res_t                  out_res_reg;
    logic [PCR_BITS-1:0]   period_reg;
    logic [PPC_BITS-1:0]   ppc_reg;

    logic                  advance;
    pcr_req_t              req;
    res_t                  res;
    logic [STAMP_BITS-1:0] div_stamp;

    assign advance    = in_full_reg && (!out_valid_reg || result_ready);
    assign data_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PCR_GAP_RESET;
            ppc_reg    <= PPC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PCR_GAP:        period_reg <= cfg_data[PCR_BITS-1:0];
                REG_PKTS_PER_CHUNK: ppc_reg    <= cfg_data[PPC_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (data_valid && data_ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            in_byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= in_byte_reg;
            out_res_reg  <= res;
        end
    end

    tpc_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .data_byte         (in_byte_reg),
        .pcr_gap           (period_reg),
        .packets_per_chunk (ppc_reg),
        .div_stamp         (div_stamp),
        .req               (req),
        .res               (res)
    );

    tpc_stamp_div u_stamp_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stamp (div_stamp)
    );

    assign result_valid  = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign keep          = out_res_reg.keep;
    assign chunk_last    = out_res_reg.chunk_last;
    assign timestamp     = out_res_reg.timestamp;
    assign chunk_packets = out_res_reg.chunk_packets;

endmodule

>>> bench/tb_ts_pcr_chunker_unit.sv
// Self-checking testbench for the transport stream chunker, with directed and random byte streams.
`timescale 1ns / 1ps

module tb_ts_pcr_chunker_unit;
    import tpc_pkg::*;

    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_BYTES = 280;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 250;
    localparam int FINAL_BYTES  = 380;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam logic [PCR_BITS-1:0]     PCR_MAX     = '1;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = '1;

    typedef struct {
        logic [7:0]            out_byte;
        logic                  keep;
        logic                  last;
        logic [STAMP_BITS-1:0] stamp;
        logic [NPK_BITS-1:0]   packets;
    } chunk_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       keep;
    } directed_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     data_valid;
    logic                     data_ready;
    logic [7:0]               data_byte;
    logic                     result_valid;
    logic                     result_ready;
    logic [7:0]               out_byte;
    logic                     keep;
    logic                     chunk_last;
    logic [STAMP_BITS-1:0]    timestamp;
    logic [NPK_BITS-1:0]      chunk_packets;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    logic [PCR_BITS-1:0]    period_reg;
    logic [PPC_BITS-1:0]    chunk_len_reg;
    logic [7:0]             parse_pos;
    logic                   adapt_seen;
    logic                   pcr_flagged;
    logic [GATHER_BITS-1:0] pcr_bytes;
    logic [PCR_BITS-1:0]    prev_pcr;
    logic [COUNT_BITS-1:0]  packet_count;
    logic                   cut_armed;
    logic [STAMP_BITS-1:0]  armed_stamp;

    logic                plan_adapt = 1'b0;
    logic                plan_flag  = 1'b0;
    logic [PCR_BITS-1:0] plan_pcr   = '0;
    bit                  force_max  = 1'b0;
    bit                  calm       = 1'b0;
    bit                  hold_request = 1'b0;

    chunk_result_t expected_q[$];
    int            error_count = 0;
    int            cycle_count = 0;

    directed_row_t directed_rows [24] = '{
        '{8'h00, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0}, '{8'h46, 1'b1, 1'b0},
        '{8'h48, 1'b1, 1'b0}, '{8'hC7, 1'b1, 1'b0}, '{8'h47, 1'b1, 1'b1},
        '{8'h47, 1'b1, 1'b1}, '{8'h1F, 1'b1, 1'b1}, '{8'h30, 1'b1, 1'b1},
        '{8'h00, 1'b1, 1'b1}, '{8'h10, 1'b1, 1'b1}, '{8'h00, 1'b0, 1'b1},
        '{8'h00, 1'b0, 1'b1}, '{8'h8C, 1'b0, 1'b1}, '{8'hA0, 1'b0, 1'b1},
        '{8'h80, 1'b0, 1'b1}, '{8'hFF, 1'b1, 1'b1}, '{8'h00, 1'b1, 1'b1},
        '{8'h47, 1'b1, 1'b1}, '{8'hAA, 1'b1, 1'b1}, '{8'h55, 1'b1, 1'b1},
        '{8'h01, 1'b1, 1'b1}, '{8'h80, 1'b1, 1'b1}, '{8'h7F, 1'b1, 1'b1}
    };

    ts_pcr_chunker_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .keep         (keep),
        .chunk_last   (chunk_last),
        .timestamp    (timestamp),
        .chunk_packets(chunk_packets),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic clear_parser();
        period_reg    = PCR_GAP_RESET;
        chunk_len_reg = PPC_RESET;
        parse_pos     = 8'd0;
        adapt_seen    = 1'b0;
        pcr_flagged   = 1'b0;
        pcr_bytes     = '0;
        prev_pcr      = '0;
        packet_count  = '0;
        cut_armed     = 1'b0;
        armed_stamp   = '0;
    endtask

    function automatic chunk_result_t parse_byte(input logic [7:0] b);
        chunk_result_t         r;
        logic [PCR_BITS-1:0]   pcr;
        logic [PCR_BITS:0]     threshold;
        logic                  cut;
        r.out_byte = b;
        r.keep     = 1'b0;
        r.last     = 1'b0;
        r.stamp    = '0;
        r.packets  = '0;
        if (parse_pos == 8'd0)
        begin
            if (b == SYNC_BYTE)
            begin
                r.keep      = 1'b1;
                parse_pos   = 8'd1;
                adapt_seen  = 1'b0;
                pcr_flagged = 1'b0;
                pcr_bytes   = '0;
            end
        end
        else
        begin
            r.keep = 1'b1;
            if (parse_pos == POS_ADAPT)
                adapt_seen = (b & ADAPT_BIT) != 8'd0;
            else if (parse_pos == POS_FLAGS)
                pcr_flagged = adapt_seen && ((b & PCR_BIT) != 8'd0);
            else if (parse_pos >= POS_PCR_FIRST && parse_pos <= POS_PCR_LAST)
                pcr_bytes = {pcr_bytes[GATHER_BITS-9:0], b};
            else if (parse_pos == POS_PCR_END)
            begin
                pcr       = {pcr_bytes, b[7]};
                threshold = {1'b0, prev_pcr} + {1'b0, period_reg};
                if (pcr_flagged && period_reg != '0 && {1'b0, pcr} > threshold)
                begin
                    cut_armed   = 1'b1;
                    armed_stamp = STAMP_BITS'((64'(pcr) / 64'(PCR_DIVISOR))
                                              * 64'(STAMP_SCALE));
                    prev_pcr    = pcr;
                end
            end
            if (parse_pos == LAST_POS)
            begin
                if (packet_count != COUNT_MAX)
                    packet_count++;
                if (period_reg != '0)
                begin
                    cut     = cut_armed;
                    r.stamp = armed_stamp;
                end
                else
                    cut = packet_count >= chunk_len_reg;
                if (cut)
                begin
                    r.last       = 1'b1;
                    r.packets    = NPK_BITS'(packet_count);
                    packet_count = '0;
                end
                else
                    r.stamp = '0;
                cut_armed = 1'b0;
                parse_pos = 8'd0;
            end
            else
                parse_pos++;
        end
        return r;
    endfunction

    function automatic logic [7:0] next_stream_byte();
        logic [7:0]        b;
        logic [PCR_BITS:0] threshold;
        int                shift;
        b = 8'($urandom);
        if (parse_pos == 8'd0)
        begin
            if (!force_max && $urandom_range(0, 99) < 8)
            begin
                if (b == SYNC_BYTE)
                    b = ~b;
            end
            else
            begin
                b          = SYNC_BYTE;
                plan_adapt = force_max || $urandom_range(0, 3) != 0;
                plan_flag  = force_max || $urandom_range(0, 3) != 0;
                threshold  = {1'b0, prev_pcr} + {1'b0, period_reg};
                if (force_max)
                    plan_pcr = PCR_MAX;
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5:
                            if (threshold + 34'd5001 <= {1'b0, PCR_MAX})
                                plan_pcr = PCR_BITS'(threshold + 34'd1
                                                     + 34'($urandom_range(0, 5000)));
                            else
                                plan_pcr = PCR_BITS'({$urandom, $urandom});
                        6, 7:
                            plan_pcr = (threshold > {1'b0, PCR_MAX}) ? PCR_MAX
                                                                    : threshold[PCR_BITS-1:0];
                        8:
                            plan_pcr = prev_pcr >> 1;
                        default:
                            plan_pcr = PCR_BITS'({$urandom, $urandom});
                    endcase
                end
            end
        end
        else if (parse_pos == POS_ADAPT)
            b = plan_adapt ? (b | ADAPT_BIT) : (b & ~ADAPT_BIT);
        else if (parse_pos == POS_FLAGS)
            b = plan_flag ? (b | PCR_BIT) : (b & ~PCR_BIT);
        else if (parse_pos >= POS_PCR_FIRST && parse_pos <= POS_PCR_LAST)
        begin
            shift = PCR_BITS - 1 - 8 * int'(parse_pos - POS_PCR_FIRST);
            b = plan_pcr[shift -: 8];
        end
        else if (parse_pos == POS_PCR_END)
            b[7] = plan_pcr[0];
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
        error_count++;
    endtask

    task automatic offer_byte(input logic [7:0] b, input int idle_pct,
                              output chunk_result_t predicted);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        do
            @(posedge clk);
        while (!data_ready);
        predicted = parse_byte(b);
    endtask

    task automatic send_checked(input logic [7:0] b, input int idle_pct);
        chunk_result_t r;
        offer_byte(b, idle_pct, r);
        expected_q.push_back(r);
    endtask

    task automatic settle_block();
        data_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_PCR_GAP)
            period_reg = value;
        else if (idx == REG_PKTS_PER_CHUNK)
            chunk_len_reg = value[PPC_BITS-1:0];
    endtask

    initial
    begin : stimulus
        chunk_result_t            r;
        logic [CFG_DATA_BITS-1:0] period_pick;
        logic [CFG_DATA_BITS-1:0] chunk_pick;
        int                       idle_pct;
        int                       phase_len;
        int                       random_sent;
        bit                       first_phase;
        data_valid  = 1'b0;
        data_byte   = 8'd0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        random_sent = 0;
        first_phase = 1'b1;
        clear_parser();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_byte(directed_rows[i].data, 30, r);
            if (directed_rows[i].typed)
            begin
                r.out_byte = directed_rows[i].data;
                r.keep     = directed_rows[i].keep;
                r.last     = 1'b0;
                r.stamp    = '0;
                r.packets  = '0;
            end
            expected_q.push_back(r);
        end
        while (parse_pos != 8'd0)
            send_checked(next_stream_byte(), 20);

        while (random_sent < RANDOM_BYTES)
        begin
            settle_block();
            case ($urandom_range(0, 6))
                0, 1: period_pick = '0;
                2: period_pick = 33'd1;
                3: period_pick = PCR_GAP_RESET;
                4: period_pick = PCR_MAX;
                5: period_pick = CFG_DATA_BITS'($urandom_range(1, 200000));
                default: period_pick = CFG_DATA_BITS'({$urandom, $urandom});
            endcase
            case ($urandom_range(0, 5))
                0: chunk_pick = '0;
                1: chunk_pick = 33'd1;
                2: chunk_pick = 33'd2;
                3: chunk_pick = 33'hFFFF;
                4: chunk_pick = CFG_DATA_BITS'($urandom_range(1, 4));
                default: chunk_pick = CFG_DATA_BITS'({$urandom, $urandom});
            endcase
            write_reg(REG_PCR_GAP, period_pick);
            if (first_phase || $urandom_range(0, 3) != 0)
                write_reg(REG_PKTS_PER_CHUNK, chunk_pick);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_BITS'({$urandom, $urandom}));
            cfg_we <= 1'b0;
            first_phase = 1'b0;
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 15;
                default: idle_pct = 40;
            endcase
            phase_len = $urandom_range(30, 100);
            if (phase_len > RANDOM_BYTES - random_sent)
                phase_len = RANDOM_BYTES - random_sent;
            repeat (phase_len)
            begin
                if (random_sent == HOLD_AT)
                    hold_request = 1'b1;
                send_checked(next_stream_byte(), idle_pct);
                random_sent++;
            end
        end

        // A final packet with the largest PCR closes a chunk with the largest timestamp.
        settle_block();
        write_reg(REG_PCR_GAP, 33'd1);
        cfg_we <= 1'b0;
        calm      = 1'b1;
        force_max = 1'b1;
        repeat (FINAL_BYTES) send_checked(next_stream_byte(), 0);
        settle_block();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : receiver
        result_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < 30)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        chunk_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no request pending", out_byte, 64'd0);
            else
            begin
                want = expected_q.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_byte, want.out_byte);
                if (keep !== want.keep)
                    report_mismatch("keep", keep, want.keep);
                if (chunk_last !== want.last)
                    report_mismatch("chunk_last", chunk_last, want.last);
                if (timestamp !== want.stamp)
                    report_mismatch("timestamp", timestamp, want.stamp);
                if (chunk_packets !== want.packets)
                    report_mismatch("chunk_packets", chunk_packets, want.packets);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
